FILE: hdl/assert_macros.svh
// assert_macros.svh: assertion shorthands for the deframer checkers.
// No dependencies; include this file by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge once reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequent on the following edge.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sld_pkg.sv
// sld_pkg: shared types and constants of the sync/length/XOR packet deframer.
// No dependencies.
`timescale 1ns / 1ps

package sld_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK3 = 3'd4;

    localparam logic [7:0] SYNC_RESET = 8'hAA;
    // Shortest legal frame: sync, length, id, checksum
    localparam logic [7:0] LEN_MIN    = 8'd4;
    // Offset from a payload index to its frame length when it is the final byte
    localparam logic [7:0] LAST_OFS   = 8'd5;
    // Frame position of the first payload byte
    localparam logic [7:0] BODY_START = 8'd3;

    typedef struct packed {
        logic [7:0]   sync_value;
        logic [255:0] id_mask;
    } t_cfg;

    typedef enum logic [1:0] {
        CMP_EQ,
        CMP_RANGE,
        CMP_LT
    } t_cmp_op;

endpackage

FILE: hdl/sld_cmp_unit.sv
// sld_cmp_unit: the shared 8-bit compare unit of the deframer sequencer.
// Depends on sld_pkg.
`timescale 1ns / 1ps

module sld_cmp_unit (
    input  sld_pkg::t_cmp_op i_op,
    input  logic [7:0]       i_a,
    input  logic [7:0]       i_b,
    output logic             o_hit
);

    // Pick one comparison per cycle
    always_comb begin
        case (i_op)
            sld_pkg::CMP_EQ:    o_hit = (i_a == i_b);
            sld_pkg::CMP_RANGE: o_hit = (i_a >= sld_pkg::LEN_MIN) && (i_a <= i_b);
            sld_pkg::CMP_LT:    o_hit = (i_a < i_b);
            default:            o_hit = 1'b0;
        endcase
    end

endmodule

FILE: hdl/sld_cfg_regs.sv
// sld_cfg_regs: sync byte and command id mask registers of the deframer.
// Depends on sld_pkg.
`timescale 1ns / 1ps

module sld_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_valid,
    input  logic [sld_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [63:0]                    i_wr_data,
    output sld_pkg::t_cfg                  o_cfg
);

    logic [7:0]   r_sync;
    logic [255:0] r_mask;

    // Write one register per word; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= sld_pkg::SYNC_RESET;
            r_mask <= '0;
        end else if (i_wr_valid) begin
            case (i_wr_index)
                sld_pkg::CFG_SYNC:  r_sync          <= i_wr_data[7:0];
                sld_pkg::CFG_MASK0: r_mask[63:0]    <= i_wr_data;
                sld_pkg::CFG_MASK1: r_mask[127:64]  <= i_wr_data;
                sld_pkg::CFG_MASK2: r_mask[191:128] <= i_wr_data;
                sld_pkg::CFG_MASK3: r_mask[255:192] <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.sync_value = r_sync;
    assign o_cfg.id_mask    = r_mask;

endmodule

FILE: hdl/sld_payload_mem.sv
// sld_payload_mem: payload byte store, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sld_payload_mem #(
    parameter int DEPTH  = 60,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Store incoming payload bytes
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read word
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/sync_length_xor_packet_deframer.sv
// sync_length_xor_packet_deframer: top level, byte sequencer and result register.
// Depends on sld_pkg, sld_cmp_unit, sld_cfg_regs and sld_payload_mem.
`timescale 1ns / 1ps

// Receives frames of sync, total length, command id, payload and XOR checksum,
// one byte per word on the slave stream, and delivers the payload of each good
// frame on the master stream: tdata holds command_id then payload_byte, tuser
// flags a valid payload byte (low only for an empty-payload frame), tlast marks
// the final word of the frame. Bad sync, length or id bytes and checksum
// mismatches deliver nothing and restart the sync hunt.
// Sequence: each byte is accepted, then evaluated; the checksum byte takes an
// extra step, since the shared compare unit first tests the position, then the checksum.
// A good frame then plays out word by word (store read, present) when the
// receiver is ready; the first word follows the checksum check through a store
// read, which an empty-payload frame does not need.
// One compare unit serves the sync, length, position, checksum and last-word tests,
// so the sequencer does one test per cycle, and tready stays low through evaluation and playout.
// If the receiver stalls, the word holds on the master port until taken.
// Reset empties the sequencer, sets sync to 0xAA and clears all id masks; the
// payload store needs no clearing. Configuration writes are always taken.

module sync_length_xor_packet_deframer #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: tdata = rx_byte[7:0]
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,
    // master stream: tdata = command_id[7:0], payload_byte[15:8]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,
    // tuser = has_byte[0]
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [sld_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int STORE_DEPTH = MAX_FRAME_BYTES - 4;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CHECK,
        S_RD_ADDR,
        S_SHOW
    } t_state;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_ID,
        PH_BODY
    } t_phase;

    t_state            r_state;
    t_phase            r_phase;
    logic [7:0]        r_rx;
    logic [7:0]        r_cnt;
    logic [7:0]        r_len;
    logic [7:0]        r_id;
    logic [7:0]        r_xor;
    logic [ADDR_W-1:0] r_rd_idx;
    logic              r_out_has;
    logic              r_out_last;

    sld_pkg::t_cfg     w_cfg;
    sld_pkg::t_cmp_op  w_op;
    logic [7:0]        w_a;
    logic [7:0]        w_b;
    logic              w_hit;
    logic              w_id_ok;
    logic              w_take;
    logic              w_resync;
    logic              w_we;
    logic              w_re;
    logic [7:0]        w_pos;
    logic [7:0]        w_rdata;

    sld_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    sld_cmp_unit u_cmp (
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_hit (w_hit)
    );

    sld_payload_mem #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_pos[ADDR_W-1:0]),
        .i_wdata (r_rx),
        .i_re    (w_re),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    // Steer the shared compare unit for the current step
    always_comb begin
        w_op = sld_pkg::CMP_EQ;
        w_a  = r_rx;
        w_b  = w_cfg.sync_value;
        case (r_state)
            S_EVAL: begin
                case (r_phase)
                    PH_LEN: begin
                        w_op = sld_pkg::CMP_RANGE;
                        w_b  = MAX_LEN;
                    end
                    PH_BODY: begin
                        w_op = sld_pkg::CMP_LT;
                        w_a  = r_cnt + 8'd1;
                        w_b  = r_len;
                    end
                    default: ;
                endcase
            end
            S_CHECK: begin
                w_b = r_xor;
            end
            S_RD_ADDR: begin
                w_a = 8'(r_rd_idx) + sld_pkg::LAST_OFS;
                w_b = r_len;
            end
            default: ;
        endcase
    end

    assign w_id_ok = w_cfg.id_mask[r_rx];
    assign w_pos   = r_cnt - sld_pkg::BODY_START;

    // Fold a good byte into the frame, or drop the frame and hunt again
    always_comb begin
        w_take   = 1'b0;
        w_resync = 1'b0;
        if (r_state == S_EVAL) begin
            case (r_phase)
                PH_HUNT: w_take = w_hit;
                PH_LEN: begin
                    w_take   = w_hit;
                    w_resync = !w_hit;
                end
                PH_ID: begin
                    w_take   = w_id_ok;
                    w_resync = !w_id_ok;
                end
                PH_BODY: w_take = w_hit;
                default: ;
            endcase
        end else if (r_state == S_CHECK) begin
            w_resync = !w_hit;
        end else if (r_state == S_SHOW) begin
            w_resync = i_m_axis_tready && r_out_last;
        end
    end

    assign w_we = (r_state == S_EVAL) && (r_phase == PH_BODY) && w_hit;
    assign w_re = (r_state == S_RD_ADDR);

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_HUNT;
            r_cnt      <= '0;
            r_len      <= '0;
            r_id       <= '0;
            r_xor      <= '0;
            r_rd_idx   <= '0;
            r_out_has  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_rx    <= i_s_axis_tdata;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= S_IDLE;
                    case (r_phase)
                        PH_HUNT: begin
                            if (w_hit) begin
                                r_phase <= PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            if (w_hit) begin
                                r_len   <= r_rx;
                                r_phase <= PH_ID;
                            end
                        end
                        PH_ID: begin
                            if (w_id_ok) begin
                                r_id    <= r_rx;
                                r_phase <= PH_BODY;
                            end
                        end
                        PH_BODY: begin
                            if (!w_hit) begin
                                r_state <= S_CHECK;
                            end
                        end
                        default: ;
                    endcase
                end
                S_CHECK: begin
                    r_rd_idx <= '0;
                    if (!w_hit) begin
                        r_state <= S_IDLE;
                    end else if (r_len == sld_pkg::LEN_MIN) begin
                        r_out_has  <= 1'b0;
                        r_out_last <= 1'b1;
                        r_state    <= S_SHOW;
                    end else begin
                        r_state <= S_RD_ADDR;
                    end
                end
                S_RD_ADDR: begin
                    r_out_has  <= 1'b1;
                    r_out_last <= w_hit;
                    r_state    <= S_SHOW;
                end
                S_SHOW: begin
                    if (i_m_axis_tready) begin
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rd_idx <= r_rd_idx + ADDR_W'(1);
                            r_state  <= S_RD_ADDR;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // Advance the checksum and byte count
            if (w_take) begin
                r_xor <= r_xor ^ r_rx;
                r_cnt <= r_cnt + 8'd1;
            end

            // Drop the frame and return to the sync hunt
            if (w_resync) begin
                r_phase <= PH_HUNT;
                r_cnt   <= '0;
                r_len   <= '0;
                r_id    <= '0;
                r_xor   <= '0;
            end
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_SHOW);
    assign o_m_axis_tdata  = {(r_out_has ? w_rdata : 8'd0), r_id};
    assign o_m_axis_tuser  = r_out_has;
    assign o_m_axis_tlast  = r_out_last;
    assign o_cfg_ready     = 1'b1;

endmodule

FILE: hdl/sld_checker.sv
// sld_checker: port-level assertions for the deframer, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sld_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    logic        w_overlap;
    logic        w_in_take;
    logic        w_empty_bad;
    logic        w_stall;
    logic [17:0] w_word;

    // Condense the port activity watched below
    assign w_overlap   = o_s_axis_tready && o_m_axis_tvalid;
    assign w_in_take   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_empty_bad = o_m_axis_tvalid && !o_m_axis_tuser &&
                         !(o_m_axis_tlast && (o_m_axis_tdata[15:8] == 8'd0));
    assign w_stall     = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_word      = {o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast};

    // Input is never taken while a result is on offer
    `ASSERT_CLK(a_no_overlap, i_clk, i_rst_n, !w_overlap, "ready while result pending")

    // A taken byte is evaluated before the next one is taken
    `ASSERT_NEXT(a_eval_gap, i_clk, i_rst_n, w_in_take, !o_s_axis_tready, "back-to-back byte")

    // An empty-payload word is the whole frame and carries a zero byte
    `ASSERT_CLK(a_empty_word, i_clk, i_rst_n, !w_empty_bad, "bad empty-payload word")

    // A stalled result word holds
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, w_stall, o_m_axis_tvalid && $stable(w_word), "word changed")

endmodule

bind sync_length_xor_packet_deframer sld_checker u_sld_checker (.*);
